// File: hw/rtl/uf_pkg.sv
// Shared operation codes, field widths and the result type of the union-find table.
`timescale 1ns / 1ps

package uf_pkg;

  // Width of a node number and of a returned root on the ports.
  localparam int FIELD_W = 10;

  // Operation codes as they arrive on the input channel.
  localparam int FUNC_W = 2;
  localparam logic [FUNC_W-1:0] FUNC_FIND  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_JOIN  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RSVD  = 2'd3;

  // Depth of the queues between the front, the back and the result side.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [FIELD_W-1:0] root;
    logic               same;
  } res_t;

endpackage

// File: hw/rtl/uf_fifo.sv
// Small first-in first-out queue used between the front, the back and the result ports.
`timescale 1ns / 1ps

module uf_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hw/rtl/uf_front.sv
// Front end: takes requests, folds node numbers into range and sorts out the operation.
`timescale 1ns / 1ps

module uf_front
  import uf_pkg::*;
#(
  parameter int NODES = 1024,
  parameter int NW    = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               hold,
  input  logic               in_push,
  output logic               in_full,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [FIELD_W-1:0] in_node_a,
  input  logic [FIELD_W-1:0] in_node_b,
  output logic               cmd_push,
  input  logic               cmd_full,
  output logic [FUNC_W-1:0]  cmd_op,
  output logic [NW-1:0]      cmd_a,
  output logic [NW-1:0]      cmd_b
);

  // Node numbers are folded into range by a reciprocal multiply: the quotient comes from the
  // high bits of the product with a rounded-up reciprocal, then quotient times NODES is
  // subtracted. Twenty fraction bits make the quotient exact for every 10-bit number.
  localparam bit                  FOLD       = (NODES < (1 << FIELD_W));
  localparam int                  RECIP_SH   = 2 * FIELD_W;
  localparam int                  PROD_W     = FIELD_W + RECIP_SH;
  localparam logic [RECIP_SH-1:0] RECIP      =
    FOLD ? RECIP_SH'(((1 << RECIP_SH) + NODES - 1) / NODES) : '0;
  localparam logic [FIELD_W-1:0]  DVS        = FOLD ? FIELD_W'(NODES) : '0;
  localparam logic [1:0]          FOLD_STEPS = FOLD ? 2'd2 : 2'd0;

  logic                busy_r, busy_nxt;
  logic [1:0]          step_r, step_nxt;
  logic [FUNC_W-1:0]   op_r, op_nxt;
  logic [FIELD_W-1:0]  a_r, a_nxt;
  logic [FIELD_W-1:0]  b_r, b_nxt;
  logic [FIELD_W-1:0]  qa_r, qa_nxt;
  logic [FIELD_W-1:0]  qb_r, qb_nxt;
  logic                accept, done;
  logic [PROD_W-1:0]   prod_a, prod_b;
  logic [FIELD_W-1:0]  back_a, back_b;
  logic [FUNC_W-1:0]   in_op;

  assign done     = busy_r && (step_r == 2'd0) && !cmd_full;
  assign in_full  = hold || (busy_r && !done);
  assign accept   = in_push && !in_full;
  assign cmd_push = done;
  assign cmd_op   = op_r;
  assign cmd_a    = NW'(a_r);
  assign cmd_b    = NW'(b_r);

  // The reserved code runs as a find.
  assign in_op = ((in_func == FUNC_CHECK) || (in_func == FUNC_JOIN)) ? in_func : FUNC_FIND;

  assign prod_a = PROD_W'(a_r) * PROD_W'(RECIP);
  assign prod_b = PROD_W'(b_r) * PROD_W'(RECIP);
  // The true product never exceeds the node number, so ten bits hold it.
  assign back_a = qa_r * DVS;
  assign back_b = qb_r * DVS;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    op_nxt   = op_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    qa_nxt   = qa_r;
    qb_nxt   = qb_r;
    if (accept) begin
      busy_nxt = 1'b1;
      step_nxt = FOLD_STEPS;
      op_nxt   = in_op;
      a_nxt    = in_node_a;
      b_nxt    = in_node_b;
    end else if (busy_r && (step_r == 2'd2)) begin
      step_nxt = 2'd1;
      qa_nxt   = prod_a[PROD_W-1:RECIP_SH];
      qb_nxt   = prod_b[PROD_W-1:RECIP_SH];
    end else if (busy_r && (step_r == 2'd1)) begin
      step_nxt = 2'd0;
      a_nxt    = a_r - back_a;
      b_nxt    = b_r - back_b;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    qa_r <= qa_nxt;
    qb_r <= qb_nxt;
  end

endmodule

// File: hw/rtl/uf_back.sv
// Back end: parent table memory and the walker that finds roots, compresses paths and joins.
`timescale 1ns / 1ps

module uf_back
  import uf_pkg::*;
#(
  parameter int NODES = 1024,
  parameter int NW    = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  output logic              clearing,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  input  logic [FUNC_W-1:0] cmd_op,
  input  logic [NW-1:0]     cmd_a,
  input  logic [NW-1:0]     cmd_b,
  input  logic              res_full,
  output logic              res_push,
  output res_t              res_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_COMP  = 3'd3;
  localparam logic [2:0] S_JOIN  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [NW-1:0]     mem [NODES];
  logic [NW-1:0]     rd_r;

  logic [2:0]        state_r, state_nxt;
  logic [NW-1:0]     clr_r, clr_nxt;
  logic              phase_r, phase_nxt;
  logic [FUNC_W-1:0] op_r, op_nxt;
  logic [NW-1:0]     b_r, b_nxt;
  logic [NW-1:0]     start_r, start_nxt;
  logic [NW-1:0]     cur_r, cur_nxt;
  logic [NW-1:0]     root_r, root_nxt;
  logic [NW-1:0]     ra_r, ra_nxt;
  logic              same_r, same_nxt;

  logic              we;
  logic [NW-1:0]     waddr, wdata, raddr;

  assign clearing      = (state_r == S_CLEAR);
  assign res_push      = (state_r == S_DONE) && !res_full;
  assign res_data.root = FIELD_W'(ra_r);
  assign res_data.same = same_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    phase_nxt = phase_r;
    op_nxt    = op_r;
    b_nxt     = b_r;
    start_nxt = start_r;
    cur_nxt   = cur_r;
    root_nxt  = root_r;
    ra_nxt    = ra_r;
    same_nxt  = same_r;
    cmd_pop   = 1'b0;
    we        = 1'b0;
    waddr     = cur_r;
    wdata     = root_r;
    raddr     = cur_r;
    case (state_r)
      S_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = clr_r;
        clr_nxt = clr_r + NW'(1);
        if (clr_r == NW'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop   = 1'b1;
          op_nxt    = cmd_op;
          b_nxt     = cmd_b;
          phase_nxt = 1'b0;
          same_nxt  = 1'b0;
          start_nxt = cmd_a;
          cur_nxt   = cmd_a;
          raddr     = cmd_a;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        // rd_r holds the parent of cur_r.
        if (rd_r == cur_r) begin
          root_nxt  = cur_r;
          cur_nxt   = start_r;
          raddr     = start_r;
          state_nxt = S_COMP;
        end else begin
          cur_nxt = rd_r;
          raddr   = rd_r;
        end
      end
      S_COMP: begin
        if (cur_r == root_r) begin
          if (!phase_r) begin
            ra_nxt = root_r;
            if (op_r == FUNC_FIND) begin
              state_nxt = S_DONE;
            end else begin
              phase_nxt = 1'b1;
              start_nxt = b_r;
              cur_nxt   = b_r;
              raddr     = b_r;
              state_nxt = S_WALK;
            end
          end else begin
            same_nxt = (ra_r == root_r);
            if ((op_r == FUNC_JOIN) && (ra_r != root_r)) begin
              state_nxt = S_JOIN;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end else begin
          // Repoint this node at the root and step to its old parent.
          we      = 1'b1;
          cur_nxt = rd_r;
          raddr   = rd_r;
        end
      end
      S_JOIN: begin
        we        = 1'b1;
        waddr     = root_r;
        wdata     = ra_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!res_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    op_r    <= op_nxt;
    b_r     <= b_nxt;
    start_r <= start_nxt;
    cur_r   <= cur_nxt;
    root_r  <= root_nxt;
    ra_r    <= ra_nxt;
    same_r  <= same_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

endmodule

// File: hw/rtl/union_find_table.sv
// Top level of the union-find table: front end, command queue, walker and result queue.
`timescale 1ns / 1ps

// Channel   Ports                                        Transfer when
// input     in_push, in_full, in_func, in_node_a/b       in_push high and in_full low
// result    out_pop, out_empty, out_root_of_a, out_same  out_pop high and out_empty low
//
// After reset the parent table is rewritten so that every node is its own root. While
// this pass runs, in_full stays high.
// The walker reads the parent memory through a registered port, one link per cycle, first on
// the way up to the root and again while compressing the path; a check walks from both A
// and B, and a join also relinks one root when the roots differ.
// When NODES is below 1024 the front end folds node numbers into range by first forming
// the quotient and then subtracting, overlapped with the walker's work on earlier ones.
// The command and result queues let either side stall without blocking the other.

module union_find_table
  import uf_pkg::*;
#(
  parameter int NODES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [FIELD_W-1:0] in_node_a,
  input  logic [FIELD_W-1:0] in_node_b,
  input  logic               out_pop,
  output logic               out_empty,
  output logic [FIELD_W-1:0] out_root_of_a,
  output logic               out_same_set
);

  // Width of a parent entry and of a node index inside the table.
  localparam int NW    = $clog2(NODES);
  localparam int CMD_W = FUNC_W + 2 * NW;
  localparam int RES_W = $bits(res_t);

  logic              clearing;
  logic              fc_push, fc_full;
  logic [FUNC_W-1:0] fc_op;
  logic [NW-1:0]     fc_a, fc_b;
  logic [CMD_W-1:0]  cmd_in, cmd_out;
  logic              cmd_pop, cmd_empty;
  logic              res_push, res_full;
  res_t              res_in, res_out;

  uf_front #(
    .NODES (NODES),
    .NW    (NW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .hold      (clearing),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_func   (in_func),
    .in_node_a (in_node_a),
    .in_node_b (in_node_b),
    .cmd_push  (fc_push),
    .cmd_full  (fc_full),
    .cmd_op    (fc_op),
    .cmd_a     (fc_a),
    .cmd_b     (fc_b)
  );

  assign cmd_in = {fc_op, fc_a, fc_b};

  // Decoupling queue between the front end and the walker.
  uf_fifo #(
    .W     (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fc_push),
    .push_data (cmd_in),
    .full      (fc_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  uf_back #(
    .NODES (NODES),
    .NW    (NW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clearing  (clearing),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd_op    (cmd_out[CMD_W-1 -: FUNC_W]),
    .cmd_a     (cmd_out[2*NW-1 -: NW]),
    .cmd_b     (cmd_out[NW-1:0]),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in)
  );

  // Result queue: finished results wait here so the walker can start the next request.
  uf_fifo #(
    .W     (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (res_out),
    .empty     (out_empty)
  );

  assign out_root_of_a = res_out.root;
  assign out_same_set  = res_out.same;

endmodule

// File: hw/rtl/uf_checker.sv
// Port-level checks on the union-find table and the bind that attaches them.
`timescale 1ns / 1ps

module uf_checker
  import uf_pkg::*;
#(
  parameter int NODES = 1024
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input logic [FUNC_W-1:0]  in_func,
  input logic [FIELD_W-1:0] in_node_a,
  input logic [FIELD_W-1:0] in_node_b,
  input logic               out_pop,
  input logic               out_empty,
  input logic [FIELD_W-1:0] out_root_of_a,
  input logic               out_same_set
);

  // The table is being rebuilt right after reset, so no request can be taken.
  a_full_after_reset: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input accepted while the parent table is rebuilt");

  // No result is shown right after reset.
  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown right after reset");

  // A result that is not taken stays.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_root_of_a)
                                  && $stable(out_same_set)))
    else $error("waiting result changed or vanished");

  // A request that is offered but not taken is held unchanged.
  a_request_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && in_full) |=> (in_push && $stable(in_func) && $stable(in_node_a)
                              && $stable(in_node_b)))
    else $error("waiting request changed or withdrawn");

  // Every returned root names a node of the table.
  a_root_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((NODES >= (1 << FIELD_W)) || (out_root_of_a < FIELD_W'(NODES))))
    else $error("root outside the table");

endmodule

bind union_find_table uf_checker #(
  .NODES (NODES)
) u_uf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_push       (in_push),
  .in_full       (in_full),
  .in_func       (in_func),
  .in_node_a     (in_node_a),
  .in_node_b     (in_node_b),
  .out_pop       (out_pop),
  .out_empty     (out_empty),
  .out_root_of_a (out_root_of_a),
  .out_same_set  (out_same_set)
);

// File: verif/union_find_table_tb.sv
// Self-checking testbench for the union-find table: directed table, random traffic, predictor.
`timescale 1ns / 1ps

module tb;
  import uf_pkg::*;

  // The table is built at its default size, so every 10-bit node number names a real node.
  localparam int NODE_COUNT = 1024;

  // Cycles with no transfer on either side before the run is declared hung. The slowest
  // correct stretch is the clearing pass after reset or a check across two chains as deep
  // as the table. The limit sits several times above both.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 1300;
  localparam int CALM_ITEMS     = 150;   // last random items, sent and taken without idling
  localparam int LONG_HOLD      = 300;   // receiver stall that fills both queues
  localparam int TAIL_CYCLES    = 64;    // idle tail after the last result, for stray transfers

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_push       = 1'b0;
  logic               in_full;
  logic [FUNC_W-1:0]  in_func       = FUNC_FIND;
  logic [FIELD_W-1:0] in_node_a     = '0;
  logic [FIELD_W-1:0] in_node_b     = '0;
  logic               out_pop       = 1'b0;
  logic               out_empty;
  logic [FIELD_W-1:0] out_root_of_a;
  logic               out_same_set;

  union_find_table #(
    .NODES(NODE_COUNT)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_func      (in_func),
    .in_node_a    (in_node_a),
    .in_node_b    (in_node_b),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_root_of_a(out_root_of_a),
    .out_same_set (out_same_set)
  );

  always #10 clk = ~clk;

  // One row of the directed table. When known is set, root and same hold the result that
  // the row must produce; otherwise the predictor supplies it.
  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [FIELD_W-1:0] node_a;
    logic [FIELD_W-1:0] node_b;
    bit                 known;
    logic [FIELD_W-1:0] root;
    logic               same;
  } request_row_t;

  request_row_t plan[$];

  // Our own copy of the parent table, and the results still owed by the block, oldest first.
  int   parent_of [NODE_COUNT];
  res_t pending_results[$];

  int mismatch_count    = 0;
  int accepted_requests = 0;
  int returned_results  = 0;
  int quiet_cycles      = 0;

  // Traffic shaping shared between the two sides.
  bit calm         = 1'b0;   // set near the end: nobody idles any more
  bit hold_request = 1'b0;   // sender asks the receiver for one long stall
  int send_idle_pct = 20;
  int take_idle_pct = 20;
  logic [FIELD_W-1:0] pool_base = '0;

  // Walk from a node to its root, then point every node on the way straight at the root.
  function automatic int find_and_compress(int start);
    int root;
    int cur;
    int nxt;
    int steps;
    root  = start;
    steps = 0;
    while (parent_of[root] != root && steps < NODE_COUNT) begin
      root = parent_of[root] % NODE_COUNT;
      steps++;
    end
    cur   = start;
    steps = 0;
    while (cur != root && steps < NODE_COUNT) begin
      nxt            = parent_of[cur] % NODE_COUNT;
      parent_of[cur] = root;
      cur            = nxt;
      steps++;
    end
    return root;
  endfunction

  // Apply one request to the predicted table and return the result it must produce.
  // Find and the reserved code touch only A and report same as 0.
  function automatic res_t predict_request(logic [FUNC_W-1:0] func, logic [FIELD_W-1:0] a,
                                           logic [FIELD_W-1:0] b);
    int   root_a;
    int   root_b;
    res_t r;
    root_a = find_and_compress(int'(a) % NODE_COUNT);
    r.same = 1'b0;
    if (func == FUNC_CHECK || func == FUNC_JOIN) begin
      root_b = find_and_compress(int'(b) % NODE_COUNT);
      r.same = (root_a == root_b);
      if (func == FUNC_JOIN && root_a != root_b) parent_of[root_b] = root_a;
    end
    r.root = FIELD_W'(root_a);
    return r;
  endfunction

  // Print one line per mismatch and count it.
  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at result %0d: %s got %0d, want %0d", returned_results, what, got,
             want);
    mismatch_count++;
  endtask

  // Most node numbers come from a small sliding window so that sets actually merge and
  // paths grow; the rest cover the whole range and every bit of the field.
  function automatic logic [FIELD_W-1:0] pick_node();
    if ($urandom_range(0, 3) == 0) return FIELD_W'($urandom_range(0, NODE_COUNT - 1));
    return FIELD_W'(pool_base + $urandom_range(0, 47));
  endfunction

  // Offer one request and hold it until the block takes it. The push stays high on return so
  // that back-to-back requests never lower and raise it within one time step; an optional
  // idle burst in front of the request lowers it first. At the edge of the transfer the
  // expected result is worked out and queued.
  task automatic send_request(logic [FUNC_W-1:0] func, logic [FIELD_W-1:0] a,
                              logic [FIELD_W-1:0] b, bit known, logic [FIELD_W-1:0] root,
                              logic same);
    res_t predicted;
    if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_push   <= 1'b1;
    in_func   <= func;
    in_node_a <= a;
    in_node_b <= b;
    do @(posedge clk); while (in_full !== 1'b0);
    predicted = predict_request(func, a, b);
    if (known) begin
      predicted.root = root;
      predicted.same = same;
    end
    pending_results.insert(pending_results.size(), predicted);
    accepted_requests++;
    if (accepted_requests % 100 == 0) begin
      case ($urandom_range(0, 3))
        0:       send_idle_pct = 0;
        1:       send_idle_pct = 10;
        2:       send_idle_pct = 30;
        default: send_idle_pct = 60;
      endcase
      pool_base = FIELD_W'($urandom_range(0, NODE_COUNT - 1));
    end
  endtask

  // Stop offering and wait until the block has returned everything it owes. It always waits
  // for a clock edge, so the push is never lowered and raised in the same time step.
  task automatic drain_results();
    in_push <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Watchdog: any transfer on either side restarts the count of quiet cycles.
  always @(posedge clk) begin
    if ((in_push && in_full === 1'b0) || (out_pop && out_empty === 1'b0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side. The pop is driven at the edge and the outputs are read right after the
  // next edge, so they hold the values that the block presented at that transfer.
  initial begin : result_side
    res_t want;
    int   taken;
    taken = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_request) begin
        // Long stall: the sender keeps pushing until both queues fill and in_full rises.
        out_pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < take_idle_pct) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      if (out_empty === 1'b0) begin
        returned_results++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request outstanding, root", int'(out_root_of_a),
                          -1);
        end else begin
          want = pending_results.pop_front();
          if (out_root_of_a !== want.root)
            report_mismatch("root_of_a", int'(out_root_of_a), int'(want.root));
          if (out_same_set !== want.same)
            report_mismatch("same_set", int'(out_same_set), int'(want.same));
        end
        taken++;
        if (taken % 100 == 0) begin
          case ($urandom_range(0, 3))
            0:       take_idle_pct = 0;
            1:       take_idle_pct = 10;
            2:       take_idle_pct = 30;
            default: take_idle_pct = 60;
          endcase
        end
      end
    end
  end

  // Request side: reset, the directed table, random traffic, then the final drain.
  initial begin : request_side
    logic [FUNC_W-1:0]  func;
    logic [FIELD_W-1:0] base;
    int                 chain_len;
    int                 random_start;
    int                 pick;
    bit                 hold_done;
    bit                 pause_done;

    for (int i = 0; i < NODE_COUNT; i++) parent_of[i] = i;

    // Directed table. Right after reset every node is its own root, so the first rows can be
    // read off directly; the chain-building rows further down rely on the predictor.
    plan.insert(plan.size(), '{FUNC_FIND,  10'd0,    10'd0,    1'b1, 10'd0,    1'b0});
    plan.insert(plan.size(), '{FUNC_FIND,  10'd1023, 10'd1023, 1'b1, 10'd1023, 1'b0});
    plan.insert(plan.size(), '{FUNC_CHECK, 10'd0,    10'd1023, 1'b1, 10'd0,    1'b0});
    plan.insert(plan.size(), '{FUNC_CHECK, 10'd1023, 10'd1023, 1'b1, 10'd1023, 1'b1});
    // The reserved code acts as a find and reports same as 0.
    plan.insert(plan.size(), '{FUNC_RSVD,  10'd682,  10'd341,  1'b1, 10'd682,  1'b0});
    plan.insert(plan.size(), '{FUNC_JOIN,  10'd0,    10'd1023, 1'b1, 10'd0,    1'b0});
    plan.insert(plan.size(), '{FUNC_CHECK, 10'd1023, 10'd0,    1'b1, 10'd0,    1'b1});
    // Join of two nodes already in one set changes no link and reports same as 1.
    plan.insert(plan.size(), '{FUNC_JOIN,  10'd1023, 10'd0,    1'b1, 10'd0,    1'b1});
    // A find ignores B, even when B sits in a joined set.
    plan.insert(plan.size(), '{FUNC_FIND,  10'd341,  10'd1023, 1'b1, 10'd341,  1'b0});
    plan.insert(plan.size(), '{FUNC_JOIN,  10'd341,  10'd682,  1'b1, 10'd341,  1'b0});
    plan.insert(plan.size(), '{FUNC_JOIN,  10'd682,  10'd0,    1'b0, 10'd0,    1'b0});
    // Build a chain 1 -> 2 -> ... -> 6, then walk it so that it gets compressed.
    plan.insert(plan.size(), '{FUNC_JOIN,  10'd2,    10'd1,    1'b0, 10'd0,    1'b0});
    plan.insert(plan.size(), '{FUNC_JOIN,  10'd3,    10'd2,    1'b0, 10'd0,    1'b0});
    plan.insert(plan.size(), '{FUNC_JOIN,  10'd4,    10'd3,    1'b0, 10'd0,    1'b0});
    plan.insert(plan.size(), '{FUNC_JOIN,  10'd5,    10'd4,    1'b0, 10'd0,    1'b0});
    plan.insert(plan.size(), '{FUNC_JOIN,  10'd6,    10'd5,    1'b0, 10'd0,    1'b0});
    plan.insert(plan.size(), '{FUNC_FIND,  10'd1,    10'd0,    1'b0, 10'd0,    1'b0});
    plan.insert(plan.size(), '{FUNC_CHECK, 10'd1,    10'd6,    1'b0, 10'd0,    1'b0});
    plan.insert(plan.size(), '{FUNC_JOIN,  10'd1,    10'd1023, 1'b0, 10'd0,    1'b0});
    plan.insert(plan.size(), '{FUNC_FIND,  10'd1023, 10'd0,    1'b0, 10'd0,    1'b0});
    plan.insert(plan.size(), '{FUNC_RSVD,  10'd0,    10'd1023, 1'b0, 10'd0,    1'b0});
    plan.insert(plan.size(), '{FUNC_CHECK, 10'd682,  10'd2,    1'b0, 10'd0,    1'b0});
    plan.insert(plan.size(), '{FUNC_JOIN,  10'd1023, 10'd1022, 1'b0, 10'd0,    1'b0});
    plan.insert(plan.size(), '{FUNC_FIND,  10'd1022, 10'h3FF,  1'b0, 10'd0,    1'b0});

    // Synchronous reset first. The block then clears its table with in_full high,
    // which the handshake in send_request simply waits out.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i])
      send_request(plan[i].func, plan[i].node_a, plan[i].node_b, plan[i].known,
                   plan[i].root, plan[i].same);

    // Let the block go completely idle once before the random traffic starts.
    drain_results();

    random_start = accepted_requests;
    hold_done    = 1'b0;
    pause_done   = 1'b0;
    while (accepted_requests < random_start + RANDOM_ITEMS) begin
      if (!hold_done && accepted_requests >= random_start + 400) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      if (!pause_done && accepted_requests >= random_start + 800) begin
        drain_results();
        pause_done = 1'b1;
      end
      if (accepted_requests >= random_start + RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;

      if ($urandom_range(0, 99) < 12) begin
        // Grow a chain by joining each node under the next one, then walk it from the
        // bottom and check its two ends.
        base      = pick_node();
        chain_len = $urandom_range(2, 12);
        for (int k = 0; k < chain_len; k++)
          send_request(FUNC_JOIN, FIELD_W'(base + k + 1), FIELD_W'(base + k), 1'b0, '0, 1'b0);
        send_request(FUNC_FIND, base, pick_node(), 1'b0, '0, 1'b0);
        send_request(FUNC_CHECK, base, FIELD_W'(base + chain_len), 1'b0, '0, 1'b0);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 35)      func = FUNC_JOIN;
        else if (pick < 60) func = FUNC_CHECK;
        else if (pick < 88) func = FUNC_FIND;
        else                func = FUNC_RSVD;
        send_request(func, pick_node(), pick_node(), 1'b0, '0, 1'b0);
      end
    end

    // Wait for every owed result, then an idle tail to catch stray transfers.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/uf_pkg.sv
hw/rtl/uf_fifo.sv
hw/rtl/uf_front.sv
hw/rtl/uf_back.sv
hw/rtl/union_find_table.sv
hw/rtl/uf_checker.sv
verif/union_find_table_tb.sv
